// ----- sv/cbb_pkg.sv -----
// ----------------------------------------------------------------------------
// cbb_pkg
// Shared types and constants of the clipped bitmap blitter.
// ----------------------------------------------------------------------------
`default_nettype none

package cbb_pkg;

    localparam int MAX_DIM_DEF     = 4096;
    localparam int OFFSET_BITS_DEF = 28;

    // Entries of the queue between the classifier and the address stage.
    localparam int QUEUE_DEPTH = 2;

    // Signed width that holds a placement plus any bitmap column or row.
    localparam int POS_W = 18;
    // Width of the unclipped byte offset: 13-bit row times 16-bit stride
    // plus four times a 13-bit column.
    localparam int SUM_W = 30;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCREEN_WIDTH  = 3'd0,
        REG_SCREEN_HEIGHT = 3'd1,
        REG_LINE_STRIDE   = 3'd2,
        REG_BITMAP_WIDTH  = 3'd3,
        REG_BITMAP_HEIGHT = 3'd4,
        REG_PLACE_X       = 3'd5,
        REG_PLACE_Y       = 3'd6
    } t_reg_idx;

    localparam logic [12:0] SCREEN_WIDTH_RST  = 13'd640;
    localparam logic [12:0] SCREEN_HEIGHT_RST = 13'd480;
    localparam logic [15:0] LINE_STRIDE_RST   = 16'd2560;
    localparam logic [12:0] BITMAP_WIDTH_RST  = 13'd1;
    localparam logic [12:0] BITMAP_HEIGHT_RST = 13'd1;

    typedef struct packed {
        logic [12:0] screen_width;
        logic [12:0] screen_height;
        logic [15:0] line_stride;
        logic [12:0] bitmap_width;
        logic [12:0] bitmap_height;
        logic [15:0] place_x;
        logic [15:0] place_y;
    } t_cfg;

    // A classified pixel: screen coordinates are only meaningful when on_screen.
    typedef struct packed {
        logic [31:0] pixel;
        logic        on_screen;
        logic [12:0] sx;
        logic [12:0] sy;
        logic        miss;
        logic        last;
    } t_item;

endpackage

`default_nettype wire

// ----- sv/cbb_front.sv -----
// ----------------------------------------------------------------------------
// cbb_front
// Raster counters and clipping classification of each accepted pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_front #(
    parameter int MAX_DIM = cbb_pkg::MAX_DIM_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  cbb_pkg::t_cfg   i_cfg,
    input  wire             i_valid,
    output logic            o_ready,
    input  wire  [31:0]     i_pixel,
    input  wire             i_start,
    input  wire             i_full,
    output logic            o_push,
    output cbb_pkg::t_item  o_item
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int PW = cbb_pkg::POS_W;

    logic [CW-1:0] r_col, r_row;
    logic [CW-1:0] n_col, n_row;
    logic [CW-1:0] col, row;
    logic [DW-1:0] bw, bh;
    logic [DW-1:0] col_next, row_next;

    logic signed [PW-1:0] px, py, sw, sh, sx, sy;
    logic signed [PW-1:0] lo_x, hi_x, lo_y, hi_y, end_x, end_y;
    logic                 on_x, on_y;

    function automatic logic [DW-1:0] eff_dim(input logic [12:0] d);
        logic [DW-1:0] r;
        if (d == 13'd0) begin
            r = DW'(1);
        end else if (32'(d) > 32'(MAX_DIM)) begin
            r = DW'(MAX_DIM);
        end else begin
            r = DW'(d);
        end
        return r;
    endfunction

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        bw  = eff_dim(i_cfg.bitmap_width);
        bh  = eff_dim(i_cfg.bitmap_height);
        col = i_start ? '0 : r_col;
        row = i_start ? '0 : r_row;

        px = PW'($signed(i_cfg.place_x));
        py = PW'($signed(i_cfg.place_y));
        sw = $signed(PW'(i_cfg.screen_width));
        sh = $signed(PW'(i_cfg.screen_height));

        sx = px + $signed(PW'(col));
        sy = py + $signed(PW'(row));
        on_x = !sx[PW-1] && (sx < sw);
        on_y = !sy[PW-1] && (sy < sh);

        // The rectangle misses when its clipped extent is empty on either axis.
        end_x = px + $signed(PW'(bw));
        end_y = py + $signed(PW'(bh));
        lo_x  = px[PW-1] ? '0 : px;
        lo_y  = py[PW-1] ? '0 : py;
        hi_x  = (end_x < sw) ? end_x : sw;
        hi_y  = (end_y < sh) ? end_y : sh;

        o_item.pixel     = i_pixel;
        o_item.on_screen = on_x && on_y;
        o_item.sx        = sx[12:0];
        o_item.sy        = sy[12:0];
        o_item.miss      = (hi_x <= lo_x) || (hi_y <= lo_y);
        o_item.last      = (DW'(col) == bw - DW'(1)) && (DW'(row) == bh - DW'(1));

        col_next = DW'(col) + DW'(1);
        row_next = DW'(row) + DW'(1);
        n_col = r_col;
        n_row = r_row;
        if (o_push) begin
            if (col_next >= bw) begin
                n_col = '0;
                n_row = (row_next >= bh) ? '0 : row_next[CW-1:0];
            end else begin
                n_col = col_next[CW-1:0];
                n_row = row;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // The final pixel always returns the counters to the top-left corner.
    a_last_wraps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_item.last) |=> (r_col == '0 && r_row == '0))
        else $error("counters did not wrap after the last pixel");

    a_push_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into a full queue");

    a_start_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && i_start && i_cfg.place_x == 16'd0 && i_cfg.place_y == 16'd0)
            |-> (o_item.sx == 13'd0 && o_item.sy == 13'd0))
        else $error("bitmap start did not restart at the origin");

endmodule

`default_nettype wire

// ----- sv/cbb_queue.sv -----
// ----------------------------------------------------------------------------
// cbb_queue
// Short register queue between the classifier and the address stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_queue (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_push,
    input  cbb_pkg::t_item  i_item,
    output logic            o_full,
    input  wire             i_pop,
    output logic            o_valid,
    output cbb_pkg::t_item  o_item
);

    localparam int DEPTH = cbb_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW    = $clog2(DEPTH + 1);

    cbb_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd, n_wr, n_rd;
    logic [NW-1:0]  r_count, n_count;
    logic           do_pop;

    assign o_full  = (r_count == NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        if (i_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        n_count = r_count + NW'(i_push) - NW'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NW'(DEPTH))
        else $error("queue count out of range");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("queue overflow");

endmodule

`default_nettype wire

// ----- sv/cbb_back.sv -----
// ----------------------------------------------------------------------------
// cbb_back
// Framebuffer offset computation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_back #(
    parameter int OFFSET_BITS = cbb_pkg::OFFSET_BITS_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire  [15:0]            i_line_stride,
    input  wire                    i_q_valid,
    input  cbb_pkg::t_item         i_q_item,
    output logic                   o_pop,
    output logic                   o_valid,
    input  wire                    i_ready,
    output logic                   o_write_enable,
    output logic [OFFSET_BITS-1:0] o_write_offset,
    output logic [31:0]            o_write_pixel,
    output logic                   o_misses_screen,
    output logic                   o_last_pixel
);

    localparam int SW = cbb_pkg::SUM_W;

    logic                   r_valid;
    logic [OFFSET_BITS-1:0] r_offset;
    cbb_pkg::t_item         r_item;
    logic [SW-1:0]          sum;
    logic [OFFSET_BITS+SW-1:0] sum_ext;
    logic [OFFSET_BITS-1:0] n_offset;

    assign o_pop = i_q_valid && (!r_valid || i_ready);

    always_comb begin
        sum     = SW'(i_q_item.sy) * SW'(i_line_stride) + SW'({i_q_item.sx, 2'b00});
        sum_ext = (OFFSET_BITS + SW)'(sum);
        // Suppressed pixels report an offset of zero.
        n_offset = i_q_item.on_screen ? sum_ext[OFFSET_BITS-1:0] : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item   <= i_q_item;
            r_offset <= n_offset;
        end
    end

    assign o_valid         = r_valid;
    assign o_write_enable  = r_item.on_screen;
    assign o_write_offset  = r_offset;
    assign o_write_pixel   = r_item.pixel;
    assign o_misses_screen = r_item.miss;
    assign o_last_pixel    = r_item.last;

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_item.on_screen) |-> (r_offset == '0))
        else $error("suppressed pixel carries an offset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !i_ready) |=> (r_valid && $stable(r_offset)))
        else $error("stalled result changed");

endmodule

`default_nettype wire

// ----- sv/clipped_bitmap_blit.sv -----
// ----------------------------------------------------------------------------
// clipped_bitmap_blit
// Places a raster stream of ARGB32 pixels on a framebuffer at a signed
// position, clipping against the screen and generating byte offsets.
// ----------------------------------------------------------------------------
//  Channel    Direction  Transfer when             Contents
//  s_axis     in         tvalid & tready           tdata: pixel; tuser: bitmap_start
//  m_axis     out        tvalid & tready           tdata: offset, pixel; tuser: flags
//  cfg        in         i_cfg_we                  register index and write data
//
//  One pixel per clock is sustained while the output accepts; a result passes
//  through the queue and then the output register. A two-entry queue between
//  the classifier and the offset stage keeps input flowing while a result
//  waits on the output, until the queue fills. Reset is synchronous and
//  active low; it restores the configuration registers to their reset values,
//  empties the queue and output and puts the counters at the top-left corner.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_bitmap_blit #(
    parameter int MAX_DIM     = cbb_pkg::MAX_DIM_DEF,
    parameter int OFFSET_BITS = cbb_pkg::OFFSET_BITS_DEF,
    localparam int TDATA_W    = ((OFFSET_BITS + 32 + 7) / 8) * 8
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_cfg_we,
    input  wire  [cbb_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire  [cbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire                             i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  wire  [31:0]                     i_s_axis_tdata,  // pixel
    input  wire                             i_s_axis_tuser,  // bitmap_start
    output logic                            o_m_axis_tvalid,
    input  wire                             i_m_axis_tready,
    // write_offset, write_pixel, zero fill
    output logic [TDATA_W-1:0]              o_m_axis_tdata,
    // write_enable, misses_screen
    output logic [1:0]                      o_m_axis_tuser,
    output logic                            o_m_axis_tlast
);

    cbb_pkg::t_cfg  r_cfg;
    cbb_pkg::t_item f_item, q_item;
    logic           push, full, q_valid, pop;
    logic                   write_enable, misses_screen;
    logic [OFFSET_BITS-1:0] write_offset;
    logic [31:0]            write_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_width  <= cbb_pkg::SCREEN_WIDTH_RST;
            r_cfg.screen_height <= cbb_pkg::SCREEN_HEIGHT_RST;
            r_cfg.line_stride   <= cbb_pkg::LINE_STRIDE_RST;
            r_cfg.bitmap_width  <= cbb_pkg::BITMAP_WIDTH_RST;
            r_cfg.bitmap_height <= cbb_pkg::BITMAP_HEIGHT_RST;
            r_cfg.place_x       <= '0;
            r_cfg.place_y       <= '0;
        end else if (i_cfg_we) begin
            unique case (cbb_pkg::t_reg_idx'(i_cfg_addr))
                cbb_pkg::REG_SCREEN_WIDTH:  r_cfg.screen_width  <= i_cfg_data[12:0];
                cbb_pkg::REG_SCREEN_HEIGHT: r_cfg.screen_height <= i_cfg_data[12:0];
                cbb_pkg::REG_LINE_STRIDE:   r_cfg.line_stride   <= i_cfg_data;
                cbb_pkg::REG_BITMAP_WIDTH:  r_cfg.bitmap_width  <= i_cfg_data[12:0];
                cbb_pkg::REG_BITMAP_HEIGHT: r_cfg.bitmap_height <= i_cfg_data[12:0];
                cbb_pkg::REG_PLACE_X:       r_cfg.place_x       <= i_cfg_data;
                cbb_pkg::REG_PLACE_Y:       r_cfg.place_y       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    cbb_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_pixel (i_s_axis_tdata),
        .i_start (i_s_axis_tuser),
        .i_full  (full),
        .o_push  (push),
        .o_item  (f_item)
    );

    cbb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (f_item),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    cbb_back #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_line_stride   (r_cfg.line_stride),
        .i_q_valid       (q_valid),
        .i_q_item        (q_item),
        .o_pop           (pop),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_write_enable  (write_enable),
        .o_write_offset  (write_offset),
        .o_write_pixel   (write_pixel),
        .o_misses_screen (misses_screen),
        .o_last_pixel    (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = TDATA_W'({write_pixel, write_offset});
    assign o_m_axis_tuser = {misses_screen, write_enable};

    a_out_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_valid && !o_m_axis_tvalid) |=> o_m_axis_tvalid)
        else $error("queued pixel not moved to the output");

    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_m_axis_tvalid && !q_valid) |-> o_s_axis_tready)
        else $error("empty pipeline refused input");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

endmodule

`default_nettype wire

// ----- tb/clipped_bitmap_blit_test.sv -----
// ----------------------------------------------------------------------------
// clipped_bitmap_blit_test
// Self-checking bench for the clipped bitmap blitter. Pixel streams go in
// under many screen, stride, bitmap and placement settings. A scoreboard
// computes the expected framebuffer write of each pixel and checks each
// output transfer in order. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module clipped_bitmap_blit_test;

    localparam int OFS_W   = cbb_pkg::OFFSET_BITS_DEF;
    localparam int TDATA_W = ((OFS_W + 32 + 7) / 8) * 8;
    localparam int ITEM_GOAL = 1550;
    localparam int STALL_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        bit             we;
        bit [OFS_W-1:0] offset;
        bit [31:0]      pixel;
        bit             miss;
        bit             last;
    } t_blit_write;

    // Tracks the blitter geometry and raster position, and holds the
    // framebuffer writes still owed by the block.
    class blit_scoreboard;
        bit [12:0]   scr_w, scr_h, bm_w, bm_h;
        bit [15:0]   stride, org_x, org_y;
        int          col_pos, row_pos;
        t_blit_write owed_writes[$];
        int          errors;

        function new();
            scr_w   = cbb_pkg::SCREEN_WIDTH_RST;
            scr_h   = cbb_pkg::SCREEN_HEIGHT_RST;
            stride  = cbb_pkg::LINE_STRIDE_RST;
            bm_w    = cbb_pkg::BITMAP_WIDTH_RST;
            bm_h    = cbb_pkg::BITMAP_HEIGHT_RST;
            org_x   = '0;
            org_y   = '0;
            col_pos = 0;
            row_pos = 0;
            errors  = 0;
        endfunction

        function int eff_size(bit [12:0] d);
            if (d == 0) return 1;
            if (d > cbb_pkg::MAX_DIM_DEF) return cbb_pkg::MAX_DIM_DEF;
            return int'(d);
        endfunction

        function void write_reg(cbb_pkg::t_reg_idx idx, bit [15:0] v);
            case (idx)
                cbb_pkg::REG_SCREEN_WIDTH:  scr_w  = v[12:0];
                cbb_pkg::REG_SCREEN_HEIGHT: scr_h  = v[12:0];
                cbb_pkg::REG_LINE_STRIDE:   stride = v;
                cbb_pkg::REG_BITMAP_WIDTH:  bm_w   = v[12:0];
                cbb_pkg::REG_BITMAP_HEIGHT: bm_h   = v[12:0];
                cbb_pkg::REG_PLACE_X:       org_x  = v;
                cbb_pkg::REG_PLACE_Y:       org_y  = v;
                default: ;
            endcase
        endfunction

        function void note_pixel(bit [31:0] pix, bit start);
            longint      bw, bh, px, py, sw, sh, st, sx, sy, lo, hi;
            t_blit_write w;
            bw = eff_size(bm_w);
            bh = eff_size(bm_h);
            px = longint'($signed(org_x));
            py = longint'($signed(org_y));
            sw = scr_w;
            sh = scr_h;
            st = stride;
            if (start) begin
                col_pos = 0;
                row_pos = 0;
            end
            // The miss flag looks at the whole rectangle, not this pixel.
            w.miss = 0;
            lo = (px > 0) ? px : 0;
            hi = (px + bw < sw) ? px + bw : sw;
            if (hi <= lo) w.miss = 1;
            lo = (py > 0) ? py : 0;
            hi = (py + bh < sh) ? py + bh : sh;
            if (hi <= lo) w.miss = 1;
            sx = px + col_pos;
            sy = py + row_pos;
            w.we     = (sx >= 0 && sx < sw && sy >= 0 && sy < sh);
            w.offset = w.we ? OFS_W'(sy * st + 4 * sx) : '0;
            w.pixel  = pix;
            w.last   = (col_pos == bw - 1 && row_pos == bh - 1);
            owed_writes.push_back(w);
            if (col_pos + 1 >= bw) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= bh) ? 0 : row_pos + 1;
            end else begin
                col_pos = col_pos + 1;
            end
        endfunction

        function void check_write(bit [TDATA_W-1:0] data, bit [1:0] flags, bit last);
            t_blit_write e;
            if (owed_writes.size() == 0) begin
                $error("unexpected write transfer, pixel %h", data[OFS_W +: 32]);
                errors++;
                return;
            end
            e = owed_writes.pop_front();
            if (flags[0] !== e.we) begin
                $error("write_enable: expected %0d, got %0d", e.we, flags[0]);
                errors++;
            end
            if (data[OFS_W-1:0] !== e.offset) begin
                $error("write_offset: expected %h, got %h", e.offset, data[OFS_W-1:0]);
                errors++;
            end
            if (data[OFS_W +: 32] !== e.pixel) begin
                $error("write_pixel: expected %h, got %h", e.pixel, data[OFS_W +: 32]);
                errors++;
            end
            if (flags[1] !== e.miss) begin
                $error("misses_screen: expected %0d, got %0d", e.miss, flags[1]);
                errors++;
            end
            if (last !== e.last) begin
                $error("last_pixel: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [cbb_pkg::CFG_ADDR_W-1:0] i_cfg_addr;
    logic [cbb_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                           i_s_axis_tvalid;
    logic                           o_s_axis_tready;
    logic [31:0]                    i_s_axis_tdata;   // pixel
    logic                           i_s_axis_tuser;   // bitmap_start
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready;
    logic [TDATA_W-1:0]             o_m_axis_tdata;   // write_offset, write_pixel, zero fill
    logic [1:0]                     o_m_axis_tuser;   // write_enable, misses_screen
    logic                           o_m_axis_tlast;

    blit_scoreboard sb;
    bit             quiet;
    bit             hold_req;
    int             items_sent;
    int             idle_cycles;

    clipped_bitmap_blit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Any transfer on either side counts as progress.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Write sink: random stalls, plus one long hold-off on request.
    initial begin : write_sink
        int hold_left;
        hold_left = 0;
        i_m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready = 1'b0;
            end else begin
                i_m_axis_tready = quiet || ($urandom_range(99) >= 14);
            end
            @(posedge i_clk);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_write(o_m_axis_tdata, o_m_axis_tuser, o_m_axis_tlast);
        end
    end

    task automatic send_pixel(input bit [31:0] pix, input bit start);
        while (!quiet && $urandom_range(99) < 14) begin
            @(negedge i_clk);
            i_s_axis_tvalid = 1'b0;
        end
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b1;
        i_s_axis_tdata  = pix;
        i_s_axis_tuser  = start;
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_pixel(pix, start);
        items_sent++;
    endtask

    // Stops the stream and waits until every owed write has come out.
    task automatic wait_for_writes();
        @(negedge i_clk);
        i_s_axis_tvalid = 1'b0;
        while (sb.owed_writes.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input cbb_pkg::t_reg_idx idx, input bit [15:0] v);
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_addr = idx;
        i_cfg_data = v;
        sb.write_reg(idx, v);
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // One bitmap's worth of pixels, or 16 to 64 of them for a bitmap over 256;
    // a broken one has a random length and random restarts.
    task automatic send_bitmap(input bit well_formed);
        int total;
        int len;
        total = sb.eff_size(sb.bm_w) * sb.eff_size(sb.bm_h);
        if (total > 256) total = $urandom_range(16, 64);
        if (well_formed) begin
            // Now and then the first pixel lacks the start flag and relies
            // on the counters having wrapped.
            for (int k = 0; k < total; k++)
                send_pixel($urandom(), k == 0 && $urandom_range(9) != 0);
        end else begin
            len = $urandom_range(1, total + 2);
            for (int k = 0; k < len; k++)
                send_pixel($urandom(), $urandom_range(3) == 0);
        end
    endtask

    function automatic bit [15:0] pick_screen_dim();
        int r;
        r = $urandom_range(99);
        if (r < 5) return 16'd0;
        if (r < 15) return 16'($urandom_range(0, 8191));
        return 16'($urandom_range(1, 24));
    endfunction

    function automatic bit [15:0] pick_bitmap_dim();
        int r;
        r = $urandom_range(99);
        if (r < 8) return 16'd0;
        if (r < 13) return 16'($urandom_range(4097, 8191));
        if (r < 20) return 16'($urandom_range(7, 16));
        return 16'($urandom_range(1, 6));
    endfunction

    function automatic bit [15:0] pick_place();
        int r;
        r = $urandom_range(99);
        if (r < 15) return 16'($urandom_range(0, 65535));
        return 16'(int'($urandom_range(0, 40)) - 16);
    endfunction

    initial begin : stimulus
        int phase;
        int n_bitmaps;
        sb              = new();
        quiet           = 1'b0;
        hold_req        = 1'b0;
        items_sent      = 0;
        idle_cycles     = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_addr      = cbb_pkg::REG_SCREEN_WIDTH;
        i_cfg_data      = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset geometry: a single pixel at the top-left corner.
        send_pixel(32'h0000_0000, 1'b1);
        send_pixel(32'hFFFF_FFFF, 1'b0);
        wait_for_writes();

        // A zero bitmap size counts as one; place it on the far corner.
        write_reg(cbb_pkg::REG_BITMAP_WIDTH, 16'd0);
        write_reg(cbb_pkg::REG_BITMAP_HEIGHT, 16'd0);
        write_reg(cbb_pkg::REG_PLACE_X, 16'd639);
        write_reg(cbb_pkg::REG_PLACE_Y, 16'd479);
        end_writes();
        send_pixel(32'hA5A5_A5A5, 1'b1);
        send_pixel(32'h5A5A_5A5A, 1'b0);
        wait_for_writes();

        // Offset beyond the offset width wraps around.
        write_reg(cbb_pkg::REG_SCREEN_WIDTH, 16'd8191);
        write_reg(cbb_pkg::REG_SCREEN_HEIGHT, 16'd8191);
        write_reg(cbb_pkg::REG_LINE_STRIDE, 16'hFFFF);
        write_reg(cbb_pkg::REG_PLACE_X, 16'd8190);
        write_reg(cbb_pkg::REG_PLACE_Y, 16'd8190);
        end_writes();
        send_pixel(32'h8000_0001, 1'b1);
        wait_for_writes();

        // Zero screen width, then zero screen height.
        write_reg(cbb_pkg::REG_SCREEN_WIDTH, 16'd0);
        end_writes();
        send_pixel(32'h0123_4567, 1'b1);
        send_pixel(32'h89AB_CDEF, 1'b0);
        wait_for_writes();
        write_reg(cbb_pkg::REG_SCREEN_WIDTH, 16'd640);
        write_reg(cbb_pkg::REG_SCREEN_HEIGHT, 16'd0);
        end_writes();
        send_pixel(32'hFEDC_BA98, 1'b1);
        wait_for_writes();

        // Oversized bitmap clamps to the largest size; with a placement of
        // minus that size it just misses the screen.
        write_reg(cbb_pkg::REG_SCREEN_HEIGHT, 16'd480);
        write_reg(cbb_pkg::REG_BITMAP_WIDTH, 16'd8191);
        write_reg(cbb_pkg::REG_BITMAP_HEIGHT, 16'd8191);
        write_reg(cbb_pkg::REG_PLACE_X, 16'hF000);
        write_reg(cbb_pkg::REG_PLACE_Y, 16'd0);
        end_writes();
        send_pixel(32'h1111_1111, 1'b1);
        send_pixel(32'h2222_2222, 1'b0);
        send_pixel(32'h3333_3333, 1'b0);
        wait_for_writes();
        write_reg(cbb_pkg::REG_PLACE_X, 16'd0);
        write_reg(cbb_pkg::REG_PLACE_Y, 16'hF000);
        end_writes();
        send_pixel(32'h4444_4444, 1'b0);
        wait_for_writes();

        // Most negative column and most positive row.
        write_reg(cbb_pkg::REG_BITMAP_WIDTH, 16'd2);
        write_reg(cbb_pkg::REG_BITMAP_HEIGHT, 16'd2);
        write_reg(cbb_pkg::REG_PLACE_X, 16'h8000);
        write_reg(cbb_pkg::REG_PLACE_Y, 16'h7FFF);
        end_writes();
        for (int k = 0; k < 4; k++) send_pixel($urandom(), k == 0);
        wait_for_writes();

        // Clipping on the left and top edges of a tiny screen, smallest stride, and
        // one pixel past the end that starts the next bitmap on its own.
        write_reg(cbb_pkg::REG_SCREEN_WIDTH, 16'd2);
        write_reg(cbb_pkg::REG_SCREEN_HEIGHT, 16'd2);
        write_reg(cbb_pkg::REG_LINE_STRIDE, 16'd4);
        write_reg(cbb_pkg::REG_BITMAP_WIDTH, 16'd3);
        write_reg(cbb_pkg::REG_BITMAP_HEIGHT, 16'd3);
        write_reg(cbb_pkg::REG_PLACE_X, 16'hFFFF);
        write_reg(cbb_pkg::REG_PLACE_Y, 16'hFFFF);
        end_writes();
        for (int k = 0; k < 10; k++) send_pixel($urandom(), k == 0);

        phase = 0;
        while (items_sent < ITEM_GOAL) begin
            wait_for_writes();
            phase++;
            quiet = 1'b0;
            if ($urandom_range(9) < 7)
                write_reg(cbb_pkg::REG_SCREEN_WIDTH, pick_screen_dim());
            if ($urandom_range(9) < 7)
                write_reg(cbb_pkg::REG_SCREEN_HEIGHT, pick_screen_dim());
            if ($urandom_range(9) < 4)
                write_reg(cbb_pkg::REG_LINE_STRIDE, 16'($urandom_range(0, 65535)));
            else if ($urandom_range(9) < 7)
                write_reg(cbb_pkg::REG_LINE_STRIDE, 16'($urandom_range(4, 256)));
            if ($urandom_range(9) < 7)
                write_reg(cbb_pkg::REG_BITMAP_WIDTH, pick_bitmap_dim());
            if ($urandom_range(9) < 7)
                write_reg(cbb_pkg::REG_BITMAP_HEIGHT, pick_bitmap_dim());
            if ($urandom_range(9) < 7) write_reg(cbb_pkg::REG_PLACE_X, pick_place());
            if ($urandom_range(9) < 7) write_reg(cbb_pkg::REG_PLACE_Y, pick_place());
            if (phase == 4 || phase == 10) begin
                write_reg(cbb_pkg::REG_BITMAP_WIDTH, 16'd12);
                write_reg(cbb_pkg::REG_BITMAP_HEIGHT, 16'd12);
            end
            end_writes();
            // The sink holds off while the source keeps offering pixels,
            // so the block backs up and stalls its input.
            if (phase == 4) hold_req = 1'b1;
            if (phase == 10) quiet = 1'b1;
            if (phase == 4 || phase == 10) begin
                send_bitmap(1'b1);
            end else begin
                n_bitmaps = $urandom_range(1, 4);
                for (int b = 0; b < n_bitmaps; b++) send_bitmap($urandom_range(99) < 85);
            end
        end

        wait_for_writes();
        repeat (10) @(posedge i_clk);
        if (sb.errors == 0 && sb.owed_writes.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
